// File: rtl/core/sobel_pkg.sv
// Shared types and constants for the Sobel edge magnitude core.
// Used by sobel_ctrl, sobel_dp and sobel_edge_magnitude_core; no dependencies.
package sobel_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int ROW_W   = 10;
    localparam int COL_W   = 10;
    localparam int MAG_W   = 8;
    localparam int GRAD_W  = 11;
    localparam int SQ_W    = 20;
    localparam int SUM_W   = 21;
    localparam int DIM_XW  = 14;
    localparam int ROOT_IW = 3;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // Register indexes on the configuration port
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POS,
        S_READ,
        S_SHIFT,
        S_GRAD,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic pos;
        logic read;
        logic shift;
        logic grad;
        logic square;
        logic sum;
        logic root_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic interior;
        logic root_done;
        logic out_free;
    } t_status;

    // Clamp a frame dimension into [3, hi]
    function automatic logic [DIM_XW-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                    input logic [DIM_XW-1:0] hi);
        logic [DIM_XW-1:0] ext;
        ext = DIM_XW'(v);
        if (ext < DIM_XW'(3)) begin
            return DIM_XW'(3);
        end else if (ext > hi) begin
            return hi;
        end
        return ext;
    endfunction

endpackage

// File: rtl/core/sobel_edge_magnitude_core.sv
// Sobel 3x3 edge magnitude core: top level joining sobel_ctrl and sobel_dp.
// Depends on sobel_pkg, sobel_ctrl and sobel_dp.
//
// Takes 8-bit grey pixels in raster order (tuser marks the first pixel of a
// frame) and returns, for every interior pixel, floor(sqrt(gx^2 + gy^2))
// saturated to 255 with its row, column and a last-of-frame flag on tlast.
// Border pixels give no result. One pixel request is handled at a time: a
// border pixel passes the position step and the line store read and
// write-back before the next ready; an interior pixel also passes the
// gradient, squaring and sum stages, the eight-step square root loop and the
// hand-over to the output register, held until that register is free. The
// result waits in the output register, so the next pixel is taken meanwhile.
// Frame size is set by two registers (index 0: width, index 1: height),
// clamped into [3, MAX_WIDTH] and [3, MAX_HEIGHT]; write them while idle.
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [sobel_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [sobel_pkg::TDATA_IN_W-1:0]    i_s_axis_tdata,  // [7:0] pixel
    input  logic                                i_s_axis_tuser,  // [0] frame_start
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] magnitude, [17:8] centre_row, [27:18] centre_col, [31:28] zero
    output logic [sobel_pkg::TDATA_OUT_W-1:0]   o_m_axis_tdata,
    output logic                                o_m_axis_tlast   // last_of_frame
);

    sobel_pkg::t_cmd    cmd;
    sobel_pkg::t_status status;

    logic [sobel_pkg::MAG_W-1:0] magnitude;
    logic [sobel_pkg::ROW_W-1:0] centre_row;
    logic [sobel_pkg::COL_W-1:0] centre_col;

    sobel_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    sobel_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pixel         (i_s_axis_tdata[sobel_pkg::PIX_W-1:0]),
        .i_frame_start   (i_s_axis_tuser),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_magnitude     (magnitude),
        .o_centre_row    (centre_row),
        .o_centre_col    (centre_col),
        .o_last_of_frame (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = sobel_pkg::TDATA_OUT_W'({centre_col, centre_row, magnitude});

endmodule

// File: rtl/core/sobel_ctrl.sv
// Sequencer for the Sobel edge magnitude core: one pixel request at a time.
// Depends on sobel_pkg for the state, command and status types.
module sobel_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  sobel_pkg::t_status i_status,
    output sobel_pkg::t_cmd    o_cmd
);

    sobel_pkg::t_state r_state;
    sobel_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sobel_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            sobel_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sobel_pkg::S_POS;
                end
            end
            sobel_pkg::S_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = sobel_pkg::S_READ;
            end
            sobel_pkg::S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = sobel_pkg::S_SHIFT;
            end
            sobel_pkg::S_SHIFT: begin
                o_cmd.shift = 1'b1;
                // border pixels only update the window and line stores
                n_state = i_status.interior ? sobel_pkg::S_GRAD : sobel_pkg::S_IDLE;
            end
            sobel_pkg::S_GRAD: begin
                o_cmd.grad = 1'b1;
                n_state    = sobel_pkg::S_SQUARE;
            end
            sobel_pkg::S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = sobel_pkg::S_SUM;
            end
            sobel_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = sobel_pkg::S_ROOT;
            end
            sobel_pkg::S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_done) begin
                    n_state = sobel_pkg::S_EMIT;
                end
            end
            sobel_pkg::S_EMIT: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = sobel_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sobel_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/sobel_dp.sv
// Datapath of the Sobel edge magnitude core: position counters, line stores,
// 3x3 window, gradients, bit-serial square root and output register. Uses sobel_pkg.
module sobel_dp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [sobel_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [sobel_pkg::PIX_W-1:0]     i_pixel,
    input  logic                            i_frame_start,
    input  sobel_pkg::t_cmd                 i_cmd,
    output sobel_pkg::t_status              o_status,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [sobel_pkg::MAG_W-1:0]     o_magnitude,
    output logic [sobel_pkg::ROW_W-1:0]     o_centre_row,
    output logic [sobel_pkg::COL_W-1:0]     o_centre_col,
    output logic                            o_last_of_frame
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XW = sobel_pkg::DIM_XW;
    localparam int PW = sobel_pkg::PIX_W;
    localparam int GW = sobel_pkg::GRAD_W;

    // configuration
    logic [sobel_pkg::CFG_W-1:0] r_image_width;
    logic [sobel_pkg::CFG_W-1:0] r_image_height;
    logic [XW-1:0]               w_eff;
    logic [XW-1:0]               h_eff;

    // position
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_cur_row;
    logic [CW-1:0] r_cur_col;
    logic          r_interior;
    logic          r_last;
    logic [XW-1:0] n_row0;
    logic [XW-1:0] n_col0;
    logic [XW-1:0] n_col_inc;
    logic [XW-1:0] n_row_inc;

    // request payload
    logic [PW-1:0] r_px;
    logic          r_fs;

    // line stores
    logic [PW-1:0] mem_upper  [MAX_WIDTH];
    logic [PW-1:0] mem_middle [MAX_WIDTH];
    logic [PW-1:0] r_up_rd;
    logic [PW-1:0] r_mid_rd;

    // window and arithmetic
    logic [PW-1:0]                r_win [3][3];
    logic signed [GW-1:0]         p [3][3];
    logic signed [GW-1:0]         n_gx;
    logic signed [GW-1:0]         n_gy;
    logic signed [GW-1:0]         r_gx;
    logic signed [GW-1:0]         r_gy;
    logic signed [2*GW-1:0]       n_gx_sq;
    logic signed [2*GW-1:0]       n_gy_sq;
    logic [sobel_pkg::SQ_W-1:0]   r_gx_sq;
    logic [sobel_pkg::SQ_W-1:0]   r_gy_sq;
    logic [sobel_pkg::SUM_W-1:0]  r_sum;
    logic                         r_sat;

    // square root
    logic [sobel_pkg::MAG_W-1:0]   r_root;
    logic [sobel_pkg::ROOT_IW-1:0] r_bit_idx;
    logic [sobel_pkg::MAG_W-1:0]   n_trial;
    logic [2*sobel_pkg::MAG_W-1:0] n_trial_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= sobel_pkg::WIDTH_RESET;
            r_image_height <= sobel_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sobel_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                sobel_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff = sobel_pkg::clamp_dim(r_image_width, XW'(MAX_WIDTH));
    assign h_eff = sobel_pkg::clamp_dim(r_image_height, XW'(MAX_HEIGHT));

    // Position of the incoming pixel: frame start, wrap and row end
    always_comb begin
        n_row0 = r_fs ? '0 : XW'(r_row);
        n_col0 = r_fs ? '0 : XW'(r_col);
        if (n_row0 >= h_eff) begin
            n_row0 = '0;
        end
        if (n_col0 >= w_eff) begin
            n_col0 = '0;
            n_row0 = n_row0 + XW'(1);
            if (n_row0 >= h_eff) begin
                n_row0 = '0;
            end
        end
    end

    assign n_col_inc = XW'(r_cur_col) + XW'(1);
    assign n_row_inc = XW'(r_cur_row) + XW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.read) begin
            // advance to the pixel after the current one
            if (n_col_inc >= w_eff) begin
                r_col <= '0;
                r_row <= (n_row_inc >= h_eff) ? '0 : RW'(n_row_inc);
            end else begin
                r_col <= CW'(n_col_inc);
                r_row <= r_cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pixel;
            r_fs <= i_frame_start;
        end
        if (i_cmd.pos) begin
            r_cur_row  <= RW'(n_row0);
            r_cur_col  <= CW'(n_col0);
            r_interior <= (n_row0 >= XW'(2)) && (n_col0 >= XW'(2));
            r_last     <= (n_row0 == h_eff - XW'(1)) && (n_col0 == w_eff - XW'(1));
        end
    end

    // Line stores: read at the current column, write back in the following cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_up_rd  <= mem_upper[r_cur_col];
            r_mid_rd <= mem_middle[r_cur_col];
        end
        if (i_cmd.shift) begin
            mem_upper[r_cur_col]  <= r_mid_rd;
            mem_middle[r_cur_col] <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= r_up_rd;
            r_win[1][2] <= r_mid_rd;
            r_win[2][2] <= r_px;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                p[k][j] = signed'(GW'(r_win[k][j]));
            end
        end
        n_gx = (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1) + (p[2][2] - p[2][0]);
        n_gy = (p[2][0] + (p[2][1] <<< 1) + p[2][2])
             - (p[0][0] + (p[0][1] <<< 1) + p[0][2]);
    end

    assign n_gx_sq = r_gx * r_gx;
    assign n_gy_sq = r_gy * r_gy;

    assign n_trial    = r_root | (sobel_pkg::MAG_W'(1) << r_bit_idx);
    assign n_trial_sq = n_trial * n_trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_gx <= n_gx;
            r_gy <= n_gy;
        end
        if (i_cmd.square) begin
            r_gx_sq <= sobel_pkg::SQ_W'(unsigned'(n_gx_sq));
            r_gy_sq <= sobel_pkg::SQ_W'(unsigned'(n_gy_sq));
        end
        if (i_cmd.sum) begin
            r_sum     <= sobel_pkg::SUM_W'(r_gx_sq) + sobel_pkg::SUM_W'(r_gy_sq);
            r_root    <= '0;
            r_bit_idx <= '1;
        end else if (i_cmd.root_step) begin
            // one result bit per cycle, most significant first
            if (n_trial_sq <= r_sum[2*sobel_pkg::MAG_W-1:0]) begin
                r_root <= n_trial;
            end
            r_bit_idx <= r_bit_idx - sobel_pkg::ROOT_IW'(1);
        end
    end

    assign r_sat = |r_sum[sobel_pkg::SUM_W-1:2*sobel_pkg::MAG_W];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_magnitude     <= r_sat ? '1 : r_root;
            o_centre_row    <= sobel_pkg::ROW_W'(r_cur_row - RW'(1));
            o_centre_col    <= sobel_pkg::COL_W'(r_cur_col - CW'(1));
            o_last_of_frame <= r_last;
        end
    end

    assign o_status.interior  = r_interior;
    assign o_status.root_done = (r_bit_idx == '0);
    assign o_status.out_free  = !o_out_valid || i_out_ready;

endmodule

// File: tb/sv/sobel_edge_checker.sv
// Result checker for sobel_edge_magnitude_core: follows register writes and accepted pixel
// requests, predicts each edge result and compares it with the output stream.
// Depends on sobel_pkg.
`timescale 1ns / 100ps

module sobel_edge_checker #(
    parameter int MAX_W = 1024,
    parameter int MAX_H = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [sobel_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                              i_pix_valid,
    input  logic                              i_pix_ready,
    input  logic [sobel_pkg::TDATA_IN_W-1:0]  i_pix_data,        // [7:0] pixel
    input  logic                              i_pix_frame_start, // [0] frame_start
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    // [7:0] magnitude, [17:8] centre_row, [27:18] centre_col, [31:28] zero
    input  logic [sobel_pkg::TDATA_OUT_W-1:0] i_res_data,
    input  logic                              i_res_last,        // last_of_frame
    output int                                o_mismatches,
    output int                                o_waiting
);

    typedef struct packed {
        logic [7:0] magnitude;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } t_edge_result;

    logic [sobel_pkg::CFG_W-1:0] width_reg;
    logic [sobel_pkg::CFG_W-1:0] height_reg;
    logic [7:0]   upper_line [MAX_W];
    logic [7:0]   middle_line [MAX_W];
    logic [7:0]   win [3][3];
    int unsigned  row_pos;
    int unsigned  col_pos;
    t_edge_result edge_q [$];
    int           n_bad = 0;
    int           n_wait = 0;

    assign o_mismatches = n_bad;
    assign o_waiting    = n_wait;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (n_bad < 40) begin
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        end
        n_bad++;
    endtask

    function automatic int unsigned dim_clamp(input logic [sobel_pkg::CFG_W-1:0] v,
                                              input int unsigned hi);
        if (v < 3) begin
            return 3;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic void next_row(input int unsigned h);
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) begin
            row_pos = 0;
        end
    endfunction

    // Largest root whose square fits, held at 255 once the energy passes 255^2
    function automatic logic [7:0] floor_root_sat(input int unsigned energy);
        int unsigned root;
        if (energy >= 65536) begin
            return 8'd255;
        end
        root = 0;
        while ((root + 1) * (root + 1) <= energy) begin
            root++;
        end
        return root[7:0];
    endfunction

    task automatic predict_pixel(input logic [7:0] pix, input logic fs);
        int unsigned  w;
        int unsigned  h;
        int unsigned  r;
        int unsigned  c;
        int           gx;
        int           gy;
        t_edge_result res;
        w = dim_clamp(width_reg, MAX_W);
        h = dim_clamp(height_reg, MAX_H);
        if (fs) begin
            row_pos = 0;
            col_pos = 0;
        end
        if (row_pos >= h) begin
            row_pos = 0;
        end
        // A shrunk width ends the current row first
        if (col_pos >= w) begin
            next_row(h);
        end
        r = row_pos;
        c = col_pos;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = middle_line[c];
        win[2][2] = pix;
        upper_line[c]  = middle_line[c];
        middle_line[c] = pix;
        if (r >= 2 && c >= 2) begin
            gx = (int'(win[0][2]) - int'(win[0][0]))
               + 2 * (int'(win[1][2]) - int'(win[1][0]))
               + (int'(win[2][2]) - int'(win[2][0]));
            gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
            res.magnitude = floor_root_sat(gx * gx + gy * gy);
            res.row       = 10'(r - 1);
            res.col       = 10'(c - 1);
            res.last      = (r == h - 1) && (c == w - 1);
            edge_q.push_back(res);
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            next_row(h);
        end
    endtask

    always @(posedge i_clk) begin
        t_edge_result want;
        if (!i_rst_n) begin
            width_reg  = sobel_pkg::WIDTH_RESET;
            height_reg = sobel_pkg::HEIGHT_RESET;
            for (int k = 0; k < MAX_W; k++) begin
                upper_line[k]  = '0;
                middle_line[k] = '0;
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win[i][j] = '0;
                end
            end
            row_pos = 0;
            col_pos = 0;
            edge_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == sobel_pkg::CFG_IMAGE_WIDTH) begin
                    width_reg = i_cfg_data;
                end else begin
                    height_reg = i_cfg_data;
                end
            end
            // Retire the oldest expectation before adding one for this edge's pixel
            if (i_res_valid && i_res_ready) begin
                if (edge_q.size() == 0) begin
                    report_mismatch("unexpected result, tdata", i_res_data, 0);
                end else begin
                    want = edge_q.pop_front();
                    if (i_res_data[7:0] !== want.magnitude) begin
                        report_mismatch("magnitude", i_res_data[7:0], want.magnitude);
                    end
                    if (i_res_data[17:8] !== want.row) begin
                        report_mismatch("centre_row", i_res_data[17:8], want.row);
                    end
                    if (i_res_data[27:18] !== want.col) begin
                        report_mismatch("centre_col", i_res_data[27:18], want.col);
                    end
                    if (i_res_data[31:28] !== 4'h0) begin
                        report_mismatch("tdata padding", i_res_data[31:28], 0);
                    end
                    if (i_res_last !== want.last) begin
                        report_mismatch("last_of_frame", i_res_last, want.last);
                    end
                end
            end
            if (i_pix_valid && i_pix_ready) begin
                predict_pixel(i_pix_data[7:0], i_pix_frame_start);
            end
        end
        n_wait = edge_q.size();
    end

endmodule

// File: tb/sv/sobel_edge_magnitude_core_tb.sv
// Testbench top for sobel_edge_magnitude_core: clock, reset, register writes and pixel
// stimulus with random idling on both streams; verdict from sobel_edge_checker.
// Depends on sobel_pkg, sobel_edge_magnitude_core and sobel_edge_checker.
`timescale 1ns / 100ps

module sobel_edge_magnitude_core_tb;

    localparam int IMG_MAX = 1024;

    typedef enum int {
        PIX_NOISE,
        PIX_BINARY,
        PIX_FLAT,
        PIX_STRIPES
    } t_pix_mode;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic                              i_cfg_idx;
    logic [sobel_pkg::CFG_W-1:0]       i_cfg_data;
    logic                              i_s_axis_tvalid;
    logic                              o_s_axis_tready;
    logic [sobel_pkg::TDATA_IN_W-1:0]  i_s_axis_tdata;  // [7:0] pixel
    logic                              i_s_axis_tuser;  // [0] frame_start
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready;
    // [7:0] magnitude, [17:8] centre_row, [27:18] centre_col, [31:28] zero
    logic [sobel_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata;
    logic                              o_m_axis_tlast;  // last_of_frame

    int mismatches;
    int waiting;
    bit gaps_on = 1'b1;
    bit quiet   = 1'b0;
    bit hold_req = 1'b0;
    int cur_wv;
    int eff_w;
    int eff_h;

    sobel_edge_magnitude_core #(
        .MAX_WIDTH  (IMG_MAX),
        .MAX_HEIGHT (IMG_MAX)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    sobel_edge_checker #(
        .MAX_W (IMG_MAX),
        .MAX_H (IMG_MAX)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_pix_valid       (i_s_axis_tvalid),
        .i_pix_ready       (o_s_axis_tready),
        .i_pix_data        (i_s_axis_tdata),
        .i_pix_frame_start (i_s_axis_tuser),
        .i_res_valid       (o_m_axis_tvalid),
        .i_res_ready       (i_m_axis_tready),
        .i_res_data        (o_m_axis_tdata),
        .i_res_last        (o_m_axis_tlast),
        .o_mismatches      (mismatches),
        .o_waiting         (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(30_000_000);
        $display("sobel_edge_magnitude_core_tb: FAIL");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin
        int stall;
        int hold_left;
        stall = 0;
        hold_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                stall--;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
                    stall = $urandom_range(1, 13);
                end
            end
        end
    end

    function automatic int eff_dim(input int v);
        return (v < 3) ? 3 : ((v > IMG_MAX) ? IMG_MAX : v);
    endfunction

    task automatic send_pixel(input logic [7:0] pix, input bit fs);
        if (gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pix;
        i_s_axis_tuser  <= fs;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic write_reg(input logic idx, input int v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v[sobel_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain outstanding results and let a border pixel finish, then resize the frame
    task automatic set_frame(input int wv, input int hv);
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        write_reg(sobel_pkg::CFG_IMAGE_WIDTH, wv);
        write_reg(sobel_pkg::CFG_IMAGE_HEIGHT, hv);
        cur_wv = wv;
        eff_w  = eff_dim(wv);
        eff_h  = eff_dim(hv);
    endtask

    task automatic send_phase(input int n, input t_pix_mode mode, input bit fs_first);
        logic [7:0] pix;
        bit         fs;
        for (int k = 0; k < n; k++) begin
            case (mode)
                PIX_BINARY:  pix = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                PIX_FLAT:    pix = 8'($urandom_range(120, 123));
                PIX_STRIPES: pix = ((k % eff_w) < eff_w / 2) ? 8'd10 : 8'd240;
                default:     pix = 8'($urandom_range(0, 255));
            endcase
            // Stray frame starts break the odd frame
            fs = (k == 0 && fs_first) || ($urandom_range(0, 199) == 0);
            send_pixel(pix, fs);
        end
        i_s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        int        n_rand;
        int        n;
        int        wv;
        int        hv;
        bit        fs_first;
        bit        extremes_done;
        t_pix_mode mode;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = sobel_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        cur_wv          = sobel_pkg::WIDTH_RESET;
        extremes_done   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest frame: a hard vertical edge, then a flat frame reached by row wrap
        set_frame(3, 3);
        for (int k = 0; k < 9; k++) begin
            send_pixel((k % 3 == 2) ? 8'd255 : 8'd0, k == 0);
        end
        for (int k = 0; k < 9; k++) begin
            send_pixel(8'd0, 1'b0);
        end
        // Partial frame: one row of random pixels after a frame start
        for (int k = 0; k < 3; k++) begin
            send_pixel(8'($urandom_range(0, 255)), k == 0);
        end
        i_s_axis_tvalid <= 1'b0;

        n_rand = 0;
        while (n_rand < 1900) begin
            if (n_rand >= 1500) begin
                quiet = 1'b1;
            end
            if (!extremes_done && n_rand >= 800) begin
                extremes_done = 1'b1;
                gaps_on = 1'b1;
                set_frame(IMG_MAX, 0);
                send_phase(300, PIX_NOISE, 1'b1);
                set_frame(1, IMG_MAX);
                hold_req = 1'b1;
                send_phase(300, PIX_NOISE, 1'b1);
                n_rand += 600;
            end
            mode    = t_pix_mode'($urandom_range(0, 3));
            gaps_on = ($urandom_range(0, 3) != 0);
            // Carry on mid-frame only with a width that does not grow
            if (cur_wv >= 3 && cur_wv <= IMG_MAX && $urandom_range(0, 3) == 0) begin
                wv = $urandom_range(3, (cur_wv < 12) ? cur_wv : 12);
                fs_first = 1'b0;
            end else begin
                case ($urandom_range(0, 9))
                    0:       wv = $urandom_range(0, 2);
                    1:       wv = $urandom_range(IMG_MAX + 1, 2047);
                    2:       wv = $urandom_range(13, 40);
                    default: wv = $urandom_range(3, 12);
                endcase
                fs_first = 1'b1;
            end
            case ($urandom_range(0, 9))
                0:       hv = $urandom_range(0, 2);
                1:       hv = $urandom_range(IMG_MAX + 1, 2047);
                default: hv = $urandom_range(3, 8);
            endcase
            set_frame(wv, hv);
            n = $urandom_range(eff_w * eff_h / 2, 2 * eff_w * eff_h);
            if (n > 150) begin
                n = 150;
            end
            send_phase(n, mode, fs_first);
            n_rand += n;
        end

        @(posedge i_clk);
        for (int t = 0; t < 20000 && waiting != 0; t++) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && waiting == 0) begin
            $display("sobel_edge_magnitude_core_tb: PASS");
        end else begin
            $display("sobel_edge_magnitude_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sobel_pkg.sv
rtl/core/sobel_ctrl.sv
rtl/core/sobel_dp.sv
rtl/core/sobel_edge_magnitude_core.sv
tb/sv/sobel_edge_checker.sv
tb/sv/sobel_edge_magnitude_core_tb.sv
